/* design/prpa_pkg.sv */
// Shared definitions for the PageRank pull accumulator.
// Holds field widths, register indexes, state encoding and saturating add.
// No dependencies.
`default_nettype none

package prpa_pkg;

   localparam int unsigned VERTICES   = 1024;
   localparam int unsigned MAX_TILES  = 16;
   localparam int unsigned ADDR_W     = $clog2(VERTICES);

   localparam int unsigned SLOT_W     = 10;
   localparam int unsigned TILE_W     = 4;
   localparam int unsigned RANK_W     = 32;
   localparam int unsigned DEG_W      = 24;
   localparam int unsigned DAMP_W     = 16;
   localparam int unsigned NV_W       = 24;
   localparam int unsigned TCNT_W     = 5;

   localparam int unsigned REQ_DATA_W = 72;
   localparam int unsigned RSP_DATA_W = 48;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 24;

   localparam logic [DAMP_W-1:0] DAMP_RESET = 16'd55706;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DAMPING        = 2'd0,
      CSR_TOTAL_VERTICES = 2'd1,
      CSR_TILE_COUNT     = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EDGE_DIV,
      ST_SCALE,
      ST_MERGE,
      ST_BASE_DIV,
      ST_WRITE
   } state_type;

   function automatic logic [RANK_W-1:0] sat_add(input logic [RANK_W-1:0] a,
                                                 input logic [RANK_W-1:0] b);
      logic [RANK_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[RANK_W] ? {RANK_W{1'b1}} : s[RANK_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* design/prpa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module prpa_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/prpa_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on prpa_pkg for operand widths.
`default_nettype none

module prpa_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [prpa_pkg::RANK_W-1:0] dividend,
   input  wire logic [prpa_pkg::DEG_W-1:0]  divisor,
   output logic                             done,
   output logic      [prpa_pkg::RANK_W-1:0] quotient
);

   localparam int unsigned CNT_W = $clog2(prpa_pkg::RANK_W);

   logic [prpa_pkg::RANK_W-1:0] quo_ff, quo_in;
   logic [prpa_pkg::DEG_W-1:0]  rem_ff, rem_in;
   logic [prpa_pkg::DEG_W-1:0]  dvs_ff;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [prpa_pkg::DEG_W:0]    trial;
   logic [prpa_pkg::DEG_W:0]    diff;
   logic                        fits;

   assign trial = {rem_ff, quo_ff[prpa_pkg::RANK_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[prpa_pkg::RANK_W-2:0], fits};
         rem_in = fits ? diff[prpa_pkg::DEG_W-1:0] : trial[prpa_pkg::DEG_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(prpa_pkg::RANK_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      if (start) begin
         dvs_ff <= divisor;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* design/pagerank_pull_accumulator_core.sv */
// PageRank pull accumulator: one edge request in, one rank result per vertex out.
// An edge with nonzero out-degree goes through the one-bit-per-cycle divider before the next
// request is taken; an item with no contribution skips it. A vertex-ending item then passes
// scale, merge, base-score division in the final tile, and write, where a held result stalls it.
// Synchronous active-high reset clears control, running sum and CSR registers; RAM is not cleared.
// Depends on prpa_pkg, prpa_ram and prpa_div; partial ranks live in a 1024-entry RAM.
`default_nettype none

module pagerank_pull_accumulator_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request: vertex_slot, tile_index, source_rank, source_out_degree
   input  wire logic [prpa_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                                req_tuser,   // edge_present
   input  wire logic                                req_tlast,   // last_edge
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // result: result_slot, rank_value
   output logic      [prpa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                     rsp_tuser,   // is_final
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [prpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [prpa_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int unsigned RW = prpa_pkg::RANK_W;

   prpa_pkg::state_type state_ff, state_in;

   logic [prpa_pkg::DAMP_W-1:0] damping_ff;
   logic [prpa_pkg::NV_W-1:0]   nv_ff;
   logic [prpa_pkg::TCNT_W-1:0] tcnt_ff;

   logic [prpa_pkg::SLOT_W-1:0] slot_ff;
   logic [prpa_pkg::TILE_W-1:0] tile_ff;
   logic                        last_ff;
   logic [RW-1:0]               sum_ff, sum_in;
   logic [RW-1:0]               product_ff;
   logic [RW-1:0]               value_ff, value_in;

   logic [prpa_pkg::SLOT_W-1:0] rsp_slot_ff;
   logic [RW-1:0]               rsp_value_ff;
   logic                        rsp_final_ff;
   logic                        rsp_valid_ff;

   logic [prpa_pkg::SLOT_W-1:0] req_slot;
   logic [prpa_pkg::TILE_W-1:0] req_tile;
   logic [RW-1:0]               req_rank;
   logic [prpa_pkg::DEG_W-1:0]  req_deg;
   logic                        req_accept;
   logic                        req_contrib;

   logic                        div_start;
   logic                        div_done;
   logic [RW-1:0]               div_quo;
   logic [RW-1:0]               div_dividend;
   logic [prpa_pkg::DEG_W-1:0]  div_divisor;

   logic [RW-1:0]               ram_rd_data;
   logic                        ram_rd_en;
   logic                        ram_wr_en;

   logic [prpa_pkg::TCNT_W-1:0] tiles;
   logic                        is_final;
   logic [prpa_pkg::NV_W-1:0]   nv_eff;
   logic [prpa_pkg::DAMP_W:0]   one_minus_d;
   logic [RW-1:0]               base_num;
   logic [RW+prpa_pkg::DAMP_W-1:0] scaled;
   logic                        out_free;

   assign req_slot    = req_tdata[9:0];
   assign req_tile    = req_tdata[13:10];
   assign req_rank    = req_tdata[45:14];
   assign req_deg     = req_tdata[69:46];
   assign req_accept  = req_tvalid & req_tready;
   assign req_contrib = req_tuser & (req_deg != '0);

   assign csr_ready = 1'b1;

   always_comb begin
      if (tcnt_ff == '0) begin
         tiles = prpa_pkg::TCNT_W'(1);
      end else if (tcnt_ff > prpa_pkg::TCNT_W'(prpa_pkg::MAX_TILES)) begin
         tiles = prpa_pkg::TCNT_W'(prpa_pkg::MAX_TILES);
      end else begin
         tiles = tcnt_ff;
      end
   end

   assign is_final    = {1'b0, tile_ff} == (tiles - prpa_pkg::TCNT_W'(1));
   assign nv_eff      = (nv_ff == '0) ? prpa_pkg::NV_W'(1) : nv_ff;
   assign one_minus_d = {1'b1, {prpa_pkg::DAMP_W{1'b0}}} - {1'b0, damping_ff};
   assign base_num    = RW'({one_minus_d, 14'd0});
   assign scaled      = sum_ff * damping_ff;
   assign out_free    = ~rsp_valid_ff | rsp_tready;

   assign div_dividend = (state_ff == prpa_pkg::ST_IDLE) ? req_rank : base_num;
   assign div_divisor  = (state_ff == prpa_pkg::ST_IDLE) ? req_deg : nv_eff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prpa_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_contrib) begin
                  state_in = prpa_pkg::ST_EDGE_DIV;
               end else if (req_tlast) begin
                  state_in = prpa_pkg::ST_SCALE;
               end
            end
         end
         prpa_pkg::ST_EDGE_DIV: begin
            if (div_done) begin
               state_in = last_ff ? prpa_pkg::ST_SCALE : prpa_pkg::ST_IDLE;
            end
         end
         prpa_pkg::ST_SCALE: begin
            state_in = prpa_pkg::ST_MERGE;
         end
         prpa_pkg::ST_MERGE: begin
            state_in = is_final ? prpa_pkg::ST_BASE_DIV : prpa_pkg::ST_WRITE;
         end
         prpa_pkg::ST_BASE_DIV: begin
            if (div_done) begin
               state_in = prpa_pkg::ST_WRITE;
            end
         end
         prpa_pkg::ST_WRITE: begin
            if (out_free) begin
               state_in = prpa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = prpa_pkg::ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      ram_rd_en  = 1'b0;
      ram_wr_en  = 1'b0;
      unique case (state_ff)
         prpa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            div_start  = req_tvalid & req_contrib;
         end
         prpa_pkg::ST_SCALE: begin
            ram_rd_en = 1'b1;
         end
         prpa_pkg::ST_MERGE: begin
            div_start = is_final;
         end
         prpa_pkg::ST_WRITE: begin
            ram_wr_en = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      sum_in = sum_ff;
      if (state_ff == prpa_pkg::ST_EDGE_DIV && div_done) begin
         sum_in = prpa_pkg::sat_add(sum_ff, div_quo);
      end else if (state_ff == prpa_pkg::ST_SCALE) begin
         sum_in = '0;
      end
   end

   always_comb begin
      value_in = value_ff;
      if (state_ff == prpa_pkg::ST_MERGE) begin
         value_in = (tile_ff == '0) ? product_ff : prpa_pkg::sat_add(ram_rd_data, product_ff);
      end else if (state_ff == prpa_pkg::ST_BASE_DIV && div_done) begin
         value_in = prpa_pkg::sat_add(value_ff, div_quo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prpa_pkg::ST_IDLE;
         damping_ff   <= prpa_pkg::DAMP_RESET;
         nv_ff        <= prpa_pkg::NV_W'(1);
         tcnt_ff      <= prpa_pkg::TCNT_W'(1);
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         if (csr_valid & csr_ready) begin
            unique case (prpa_pkg::csr_index_type'(csr_index))
               prpa_pkg::CSR_DAMPING:        damping_ff <= csr_data[prpa_pkg::DAMP_W-1:0];
               prpa_pkg::CSR_TOTAL_VERTICES: nv_ff      <= csr_data[prpa_pkg::NV_W-1:0];
               prpa_pkg::CSR_TILE_COUNT:     tcnt_ff    <= csr_data[prpa_pkg::TCNT_W-1:0];
               default: begin
                  tcnt_ff <= tcnt_ff;
               end
            endcase
         end
         if (ram_wr_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         slot_ff <= req_slot;
         tile_ff <= req_tile;
         last_ff <= req_tlast;
      end
      if (state_ff == prpa_pkg::ST_SCALE) begin
         product_ff <= scaled[RW+prpa_pkg::DAMP_W-1:prpa_pkg::DAMP_W];
      end
      value_ff <= value_in;
      if (ram_wr_en) begin
         rsp_slot_ff  <= slot_ff;
         rsp_value_ff <= value_ff;
         rsp_final_ff <= is_final;
      end
   end

   prpa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   prpa_ram #(
      .WIDTH (RW),
      .DEPTH (prpa_pkg::VERTICES)
   ) u_partial_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff[prpa_pkg::ADDR_W-1:0]),
      .wr_data (value_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (slot_ff[prpa_pkg::ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp_tdata  = {6'd0, rsp_value_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_final_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire
